// File: rtl/gbpt_pkg.sv
// Package for the gravity basin pixel tracer.
// Holds the fixed-point widths, the sequencer state type and the saturation helper.
// No dependencies.
`timescale 1ns / 1ps

package gbpt_pkg;

  localparam int unsigned PixW   = 12;  // pixel coordinate
  localparam int unsigned AttrW  = 20;  // attractor coordinate, Q.8
  localparam int unsigned CapW   = 12;  // capture distance
  localparam int unsigned LimW   = 10;  // iteration limit and step count
  localparam int unsigned BasinW = 2;
  localparam int unsigned QW     = 44;  // Q20.24 position / velocity
  localparam int unsigned SumW   = 49;  // headroom for a saturating add
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 20;

  localparam logic [BasinW-1:0] BasinBg = 2'd3;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegA0X = 3'd0;
  localparam logic [CfgIdxW-1:0] RegA0Y = 3'd1;
  localparam logic [CfgIdxW-1:0] RegA1X = 3'd2;
  localparam logic [CfgIdxW-1:0] RegA1Y = 3'd3;
  localparam logic [CfgIdxW-1:0] RegA2X = 3'd4;
  localparam logic [CfgIdxW-1:0] RegA2Y = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCap = 3'd6;
  localparam logic [CfgIdxW-1:0] RegLim = 3'd7;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_CAP  = 16'h0002,
    S_CAPW = 16'h0004,
    S_STEP = 16'h0008,
    S_DIFF = 16'h0010,
    S_SQX  = 16'h0020,
    S_SQY  = 16'h0040,
    S_SUM  = 16'h0080,
    S_CMP  = 16'h0100,
    S_DIV  = 16'h0200,
    S_SCL  = 16'h0400,
    S_ACC  = 16'h0800,
    S_NEXT = 16'h1000,
    S_VEL  = 16'h2000,
    S_POS  = 16'h4000,
    S_DONE = 16'h8000
  } state_e;

  function automatic logic signed [QW-1:0] sat_q(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(signed'({1'b0, {(QW-1){1'b1}}}));
    lo = -hi - SumW'(1);
    if (v > hi) begin
      sat_q = {1'b0, {(QW-1){1'b1}}};
    end else if (v < lo) begin
      sat_q = {1'b1, {(QW-1){1'b0}}};
    end else begin
      sat_q = v[QW-1:0];
    end
  endfunction

endpackage

// File: rtl/gbpt_if.sv
// Valid/ready channels of the tracer: start pixel in, basin result out.
// Depends on gbpt_pkg for the field widths.
`timescale 1ns / 1ps

interface gbpt_pix_if;
  logic                        valid;
  logic                        ready;
  logic [gbpt_pkg::PixW-1:0]   pixel_x;
  logic [gbpt_pkg::PixW-1:0]   pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface gbpt_res_if;
  logic                        valid;
  logic                        ready;
  logic [gbpt_pkg::BasinW-1:0] basin;
  logic [gbpt_pkg::LimW-1:0]   steps_taken;
  modport source (output valid, basin, steps_taken, input ready);
  modport sink   (input valid, basin, steps_taken, output ready);
endinterface

// File: rtl/gravity_basin_pixel_tracer.sv
// One item in flight at a time. Each step runs the restoring divider twice per
//   attractor; capture exits early. The next item is taken while a result waits.
// Reset: rst_ni asynchronous active low; registers return to their reset values,
//   sequencer to idle, result channel empty.
`timescale 1ns / 1ps

module gravity_basin_pixel_tracer #(
  parameter int unsigned IMAGE_WIDTH  = 2160,
  parameter int unsigned IMAGE_HEIGHT = 3840,
  parameter int unsigned STEP_SQUARED = 400
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gbpt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gbpt_pkg::CfgDatW-1:0]  cfg_data_i,
  gbpt_pix_if.sink                      pix_i,
  gbpt_res_if.source                    res_o
);

  localparam int unsigned QW   = gbpt_pkg::QW;
  localparam int unsigned SumW = gbpt_pkg::SumW;
  localparam int unsigned PxW  = 28;  // evaluation point, Q.8
  localparam int unsigned DW   = 30;  // attractor minus point
  localparam int unsigned MagW = 29;
  localparam int unsigned D2W  = 59;  // squared distance, Q.16
  localparam int unsigned RemW = 60;
  localparam int unsigned QuoW = 33;  // quotient <= 2^32
  localparam int unsigned MulW = 33;
  localparam int unsigned AccW = 48;
  localparam int unsigned DivN = 33;

  // ---------------- configuration registers ----------------
  logic [gbpt_pkg::AttrW-1:0] ax_q [3];
  logic [gbpt_pkg::AttrW-1:0] ay_q [3];
  logic [gbpt_pkg::CapW-1:0]  cap_q;
  logic [gbpt_pkg::LimW-1:0]  lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q[0] <= 20'd171418;
      ay_q[0] <= 20'd353894;
      ax_q[1] <= 20'd447898;
      ay_q[1] <= 20'd442368;
      ax_q[2] <= 20'd232243;
      ay_q[2] <= 20'd638976;
      cap_q   <= 12'd30;
      lim_q   <= 10'd200;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gbpt_pkg::RegA0X: ax_q[0] <= cfg_data_i;
        gbpt_pkg::RegA0Y: ay_q[0] <= cfg_data_i;
        gbpt_pkg::RegA1X: ax_q[1] <= cfg_data_i;
        gbpt_pkg::RegA1Y: ay_q[1] <= cfg_data_i;
        gbpt_pkg::RegA2X: ax_q[2] <= cfg_data_i;
        gbpt_pkg::RegA2Y: ay_q[2] <= cfg_data_i;
        gbpt_pkg::RegCap: cap_q   <= cfg_data_i[gbpt_pkg::CapW-1:0];
        gbpt_pkg::RegLim: lim_q   <= cfg_data_i[gbpt_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- datapath state ----------------
  gbpt_pkg::state_e state_q, state_d;

  logic signed [QW-1:0]   pos_x_q, pos_y_q, vel_x_q, vel_y_q;
  logic [gbpt_pkg::LimW-1:0] cnt_q;
  logic [1:0]             att_q;      // attractor under evaluation
  logic                   sel_y_q;    // divider working on the y component
  logic signed [PxW-1:0]  px_q, py_q;
  logic signed [DW-1:0]   dx_q, dy_q;
  logic [D2W-1:0]         d2_q;
  logic [39:0]            cap2_q;
  logic [RemW-1:0]        rem_q;
  logic [QuoW-1:0]        quo_q;
  logic [5:0]             div_cnt_q;
  logic signed [AccW-1:0] acc_x_q, acc_y_q;
  logic [2*MulW-1:0]      mul_q;
  logic [gbpt_pkg::BasinW-1:0] basin_q;

  logic                   res_valid_q;
  logic [gbpt_pkg::BasinW-1:0] res_basin_q;
  logic [gbpt_pkg::LimW-1:0]   res_steps_q;

  // magnitudes of the offsets
  logic signed [DW-1:0] ndx, ndy;
  logic [MagW-1:0]      ux, uy;
  assign ndx = -dx_q;
  assign ndy = -dy_q;
  assign ux  = dx_q[DW-1] ? ndx[MagW-1:0] : dx_q[MagW-1:0];
  assign uy  = dy_q[DW-1] ? ndy[MagW-1:0] : dy_q[MagW-1:0];

  // shared multiplier: operands chosen by state, product registered
  logic [MulW-1:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      gbpt_pkg::S_CAP: begin
        mul_a = MulW'(cap_q);
        mul_b = MulW'(cap_q);
      end
      gbpt_pkg::S_SQX: begin
        mul_a = MulW'(ux);
        mul_b = MulW'(ux);
      end
      gbpt_pkg::S_SQY: begin
        mul_a = MulW'(uy);
        mul_b = MulW'(uy);
      end
      gbpt_pkg::S_SCL: begin
        mul_a = quo_q;
        mul_b = MulW'(STEP_SQUARED);
      end
      default: ;
    endcase
  end

  // evaluation point: integer pixel inside the image, floor to 1/256 outside
  logic in_img;
  logic signed [PxW-1:0] px_e, py_e;
  assign in_img = !pos_x_q[QW-1] && !pos_y_q[QW-1] &&
                  (pos_x_q[QW-2:24] < 19'(IMAGE_WIDTH)) &&
                  (pos_y_q[QW-2:24] < 19'(IMAGE_HEIGHT));
  assign px_e = in_img ? {pos_x_q[QW-1:24], 8'd0} : pos_x_q[QW-1:16];
  assign py_e = in_img ? {pos_y_q[QW-1:24], 8'd0} : pos_y_q[QW-1:16];

  // attractor offsets
  logic signed [DW-1:0] dx_e, dy_e;
  assign dx_e = $signed({10'd0, ax_q[att_q]}) - $signed({{2{px_q[PxW-1]}}, px_q});
  assign dy_e = $signed({10'd0, ay_q[att_q]}) - $signed({{2{py_q[PxW-1]}}, py_q});

  // one restoring division step
  logic              div_ge;
  logic [RemW-1:0]   div_sub, div_rem;
  assign div_ge  = rem_q >= {1'b0, d2_q};
  assign div_sub = rem_q - {1'b0, d2_q};
  assign div_rem = div_ge ? div_sub : rem_q;

  // scaled force term with the sign of the offset
  logic signed [AccW-1:0] term_mag, term;
  logic                   term_neg;
  assign term_mag = $signed({3'd0, mul_q[44:0]});
  assign term_neg = sel_y_q ? dy_q[DW-1] : dx_q[DW-1];
  assign term     = term_neg ? -term_mag : term_mag;

  logic done_ld;
  assign done_ld   = (state_q == gbpt_pkg::S_DONE) && (!res_valid_q || res_o.ready);
  assign pix_i.ready = (state_q == gbpt_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gbpt_pkg::S_IDLE: if (pix_i.valid) state_d = gbpt_pkg::S_CAP;
      gbpt_pkg::S_CAP:  state_d = gbpt_pkg::S_CAPW;
      gbpt_pkg::S_CAPW: state_d = gbpt_pkg::S_STEP;
      gbpt_pkg::S_STEP: state_d = (cnt_q >= lim_q) ? gbpt_pkg::S_DONE : gbpt_pkg::S_DIFF;
      gbpt_pkg::S_DIFF: state_d = gbpt_pkg::S_SQX;
      gbpt_pkg::S_SQX:  state_d = gbpt_pkg::S_SQY;
      gbpt_pkg::S_SQY:  state_d = gbpt_pkg::S_SUM;
      gbpt_pkg::S_SUM:  state_d = gbpt_pkg::S_CMP;
      gbpt_pkg::S_CMP: begin
        if (d2_q < {19'd0, cap2_q}) state_d = gbpt_pkg::S_DONE;
        else if (d2_q == '0)        state_d = gbpt_pkg::S_NEXT;
        else                        state_d = gbpt_pkg::S_DIV;
      end
      gbpt_pkg::S_DIV:  if (div_cnt_q == 6'd1) state_d = gbpt_pkg::S_SCL;
      gbpt_pkg::S_SCL:  state_d = gbpt_pkg::S_ACC;
      gbpt_pkg::S_ACC:  state_d = sel_y_q ? gbpt_pkg::S_NEXT : gbpt_pkg::S_DIV;
      gbpt_pkg::S_NEXT: state_d = (att_q == 2'd2) ? gbpt_pkg::S_VEL : gbpt_pkg::S_DIFF;
      gbpt_pkg::S_VEL:  state_d = gbpt_pkg::S_POS;
      gbpt_pkg::S_POS:  state_d = gbpt_pkg::S_STEP;
      gbpt_pkg::S_DONE: if (done_ld) state_d = gbpt_pkg::S_IDLE;
      default:          state_d = gbpt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gbpt_pkg::S_IDLE;
      res_valid_q <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
      cnt_q       <= '0;
      att_q       <= '0;
      sel_y_q     <= 1'b0;
      div_cnt_q   <= '0;
      basin_q     <= gbpt_pkg::BasinBg;
    end else begin
      state_q <= state_d;
      if (done_ld) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      unique case (state_q)
        gbpt_pkg::S_IDLE: if (pix_i.valid) begin
          pos_x_q <= $signed({8'd0, pix_i.pixel_x, 24'd0});
          pos_y_q <= $signed({8'd0, pix_i.pixel_y, 24'd0});
          vel_x_q <= '0;
          vel_y_q <= '0;
          cnt_q   <= '0;
          basin_q <= gbpt_pkg::BasinBg;
        end
        gbpt_pkg::S_STEP: att_q <= '0;
        gbpt_pkg::S_CMP: begin
          if (d2_q < {19'd0, cap2_q}) begin
            basin_q <= att_q;
          end
          sel_y_q   <= 1'b0;
          div_cnt_q <= 6'(DivN);
        end
        gbpt_pkg::S_DIV: div_cnt_q <= div_cnt_q - 6'd1;
        gbpt_pkg::S_ACC: begin
          sel_y_q   <= 1'b1;
          div_cnt_q <= 6'(DivN);
        end
        gbpt_pkg::S_NEXT: att_q <= att_q + 2'd1;
        gbpt_pkg::S_VEL: begin
          vel_x_q <= gbpt_pkg::sat_q(SumW'(vel_x_q) + SumW'(acc_x_q));
          vel_y_q <= gbpt_pkg::sat_q(SumW'(vel_y_q) + SumW'(acc_y_q));
        end
        gbpt_pkg::S_POS: begin
          pos_x_q <= gbpt_pkg::sat_q(SumW'(pos_x_q) + SumW'(vel_x_q));
          pos_y_q <= gbpt_pkg::sat_q(SumW'(pos_y_q) + SumW'(vel_y_q));
          cnt_q   <= cnt_q + 10'd1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    unique case (state_q)
      gbpt_pkg::S_CAPW: cap2_q <= {mul_q[23:0], 16'd0};
      gbpt_pkg::S_STEP: begin
        px_q    <= px_e;
        py_q    <= py_e;
        acc_x_q <= '0;
        acc_y_q <= '0;
      end
      gbpt_pkg::S_DIFF: begin
        dx_q <= dx_e;
        dy_q <= dy_e;
      end
      gbpt_pkg::S_SQY: d2_q <= mul_q[D2W-1:0];
      gbpt_pkg::S_SUM: d2_q <= d2_q + mul_q[D2W-1:0];
      gbpt_pkg::S_CMP: begin
        rem_q <= RemW'(ux);
        quo_q <= '0;
      end
      gbpt_pkg::S_DIV: begin
        rem_q <= {div_rem[RemW-2:0], 1'b0};
        quo_q <= {quo_q[QuoW-2:0], div_ge};
      end
      gbpt_pkg::S_ACC: begin
        if (sel_y_q) begin
          acc_y_q <= acc_y_q + term;
        end else begin
          acc_x_q <= acc_x_q + term;
          rem_q   <= RemW'(uy);
          quo_q   <= '0;
        end
      end
      default: ;
    endcase
    if (done_ld) begin
      res_basin_q <= basin_q;
      res_steps_q <= cnt_q;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.basin       = res_basin_q;
  assign res_o.steps_taken = res_steps_q;

  // ---------------- checks ----------------
  a_res_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_o.valid) |-> $past(state_q == gbpt_pkg::S_DONE))
    else $error("result appeared without a finished trace");

  a_cnt_le_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != gbpt_pkg::S_IDLE && state_q != gbpt_pkg::S_CAP &&
     state_q != gbpt_pkg::S_CAPW) |-> (cnt_q <= lim_q))
    else $error("step count passed the iteration limit");

  a_bg_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_ld && basin_q == gbpt_pkg::BasinBg) |-> (cnt_q == lim_q))
    else $error("background result before the limit");

  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gbpt_pkg::S_DIV) |-> (div_cnt_q != '0))
    else $error("divider ran past its last bit");

endmodule

// File: dv/gbpt_tb_if.sv
// Testbench stimulus types: command codes and the queued command record.
// Depends on gbpt_pkg for the field widths; the channels come from rtl/gbpt_if.sv.
`timescale 1ns / 1ps

package gbpt_tb_types;

  // commands for the stimulus queue of the testbench
  typedef enum logic [1:0] {
    CMD_PIX   = 2'd0,
    CMD_CFG   = 2'd1,
    CMD_DRAIN = 2'd2,
    CMD_PHASE = 2'd3
  } tb_cmd_e;

  typedef struct {
    tb_cmd_e                        kind;
    logic [gbpt_pkg::PixW-1:0]      px;
    logic [gbpt_pkg::PixW-1:0]      py;
    logic [gbpt_pkg::CfgIdxW-1:0]   idx;
    logic [gbpt_pkg::CfgDatW-1:0]   data;
    int unsigned                    idle_pct;
    int unsigned                    stall_pct;
  } tb_cmd_t;

endpackage

// File: dv/tb_gravity_basin_pixel_tracer.sv
// Testbench for gravity_basin_pixel_tracer: random and directed start pixels under
// several attractor setups, checked against a fixed-point trace predictor.
// Depends on gbpt_pkg, gbpt_if and gbpt_tb_types.
`timescale 1ns / 1ps

module tb_gravity_basin_pixel_tracer;
  import gbpt_pkg::*;
  import gbpt_tb_types::*;

  localparam longint ImgW    = 2160;
  localparam longint ImgH    = 3840;
  localparam longint StepSq  = 400;
  localparam longint QMax    = 64'sd8796093022207;
  localparam longint QMin    = -64'sd8796093022208;
  localparam int     NumRegs = 8;

  typedef struct packed {
    logic [BasinW-1:0] basin;
    logic [LimW-1:0]   steps;
  } trace_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDatW-1:0] cfg_data;

  gbpt_pix_if pix ();
  gbpt_res_if res ();

  gravity_basin_pixel_tracer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix),
    .res_o      (res)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: shadow copy of the register file, updated when written.
  // ---------------------------------------------------------------------------
  logic [CfgDatW-1:0] regs_m [NumRegs];

  tb_cmd_t    stim_q[$];
  trace_res_t basin_q[$];   // expected results, oldest first

  int unsigned n_sent, n_acc, n_res, n_err, quiet_cyc;
  int unsigned idle_pct, stall_pct;
  int unsigned basin_hits [4];
  bit          stim_done;

  function automatic longint sat_add(input longint a, input longint b);
    longint s;
    s = a + b;
    if (s > QMax) return QMax;
    if (s < QMin) return QMin;
    return s;
  endfunction

  // one force component in Q.24: sign(d) * 400 * floor(|d| * 2^32 / d2)
  function automatic longint pull(input longint d, input logic [63:0] d2);
    logic [63:0] mag, q;
    if (d2 == 0) return 0;
    mag = (d < 0) ? -d : d;
    q = (mag << 32) / d2;
    q = q * StepSq;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  // Full trace of one particle; returns the capturing basin and steps completed.
  function automatic trace_res_t trace_pixel(input logic [PixW-1:0] sx,
                                             input logic [PixW-1:0] sy);
    longint pos_x, pos_y, vel_x, vel_y, ex, ey, fx, fy, dx, dy;
    logic [63:0] ux, uy, d2, cap2;
    logic [LimW-1:0] nstep;
    logic [BasinW-1:0] bas;
    bit in_img;
    cap2 = (64'(regs_m[RegCap][CapW-1:0]) * 64'(regs_m[RegCap][CapW-1:0])) << 16;
    pos_x = longint'(sx) <<< 24;
    pos_y = longint'(sy) <<< 24;
    vel_x = 0;
    vel_y = 0;
    nstep = '0;
    bas = BasinBg;
    while (nstep < regs_m[RegLim][LimW-1:0]) begin
      in_img = pos_x >= 0 && pos_y >= 0 && pos_x < (ImgW <<< 24) && pos_y < (ImgH <<< 24);
      // on the image: whole pixel; off it: arithmetic shift floors to 1/256 pixel
      ex = in_img ? ((pos_x >>> 24) <<< 8) : (pos_x >>> 16);
      ey = in_img ? ((pos_y >>> 24) <<< 8) : (pos_y >>> 16);
      fx = 0;
      fy = 0;
      for (int a = 0; a < 3; a++) begin
        dx = longint'(regs_m[2*a]) - ex;
        dy = longint'(regs_m[2*a+1]) - ey;
        ux = (dx < 0) ? -dx : dx;
        uy = (dy < 0) ? -dy : dy;
        d2 = ux * ux + uy * uy;
        if (d2 < cap2) begin
          bas = BasinW'(a);
          break;
        end
        fx += pull(dx, d2);
        fy += pull(dy, d2);
      end
      if (bas != BasinBg) break;
      vel_x = sat_add(vel_x, fx);
      vel_y = sat_add(vel_y, fy);
      pos_x = sat_add(pos_x, vel_x);
      pos_y = sat_add(pos_y, vel_y);
      nstep++;
    end
    return '{basin: bas, steps: nstep};
  endfunction

  function automatic void shadow_write(input logic [CfgIdxW-1:0] idx,
                                       input logic [CfgDatW-1:0] d);
    case (idx)
      RegCap:  regs_m[idx] = CfgDatW'(d[CapW-1:0]);
      RegLim:  regs_m[idx] = CfgDatW'(d[LimW-1:0]);
      default: regs_m[idx] = d;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus queue helpers
  // ---------------------------------------------------------------------------
  task automatic add_pix(input int x, input int y);
    stim_q.push_back('{kind: CMD_PIX, px: PixW'(x), py: PixW'(y), idx: '0, data: '0,
                       idle_pct: 0, stall_pct: 0});
  endtask

  task automatic add_cfg(input logic [CfgIdxW-1:0] idx, input int unsigned d);
    stim_q.push_back('{kind: CMD_CFG, px: '0, py: '0, idx: idx, data: CfgDatW'(d),
                       idle_pct: 0, stall_pct: 0});
  endtask

  task automatic add_drain();
    stim_q.push_back('{kind: CMD_DRAIN, px: '0, py: '0, idx: '0, data: '0,
                       idle_pct: 0, stall_pct: 0});
  endtask

  task automatic add_phase(input int unsigned ip, input int unsigned sp);
    stim_q.push_back('{kind: CMD_PHASE, px: '0, py: '0, idx: '0, data: '0,
                       idle_pct: ip, stall_pct: sp});
  endtask

  // Random attractor setup; mostly on-image spots with a random fraction, sometimes anywhere.
  task automatic add_rand_cfg(input int unsigned lim_hi);
    for (int i = 0; i < 6; i++) begin
      if ($urandom_range(3) == 0) add_cfg(CfgIdxW'(i), $urandom_range(20'hFFFFF));
      else add_cfg(CfgIdxW'(i), ($urandom_range(2159) << 8) | $urandom_range(255));
    end
    // upper data bits are random too: register must mask them
    add_cfg(RegCap, ($urandom_range(255) << 12) | $urandom_range(80));
    add_cfg(RegLim, ($urandom_range(1023) << 10) | $urandom_range(lim_hi));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: falling edge. One valid in flight; config writes only when idle.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic v_n, we_n;
    tb_cmd_t c;
    if (rst_ni) begin
      v_n = pix.valid;
      we_n = 1'b0;
      res.ready <= ($urandom_range(99) >= stall_pct);
      quiet_cyc = (basin_q.size() == 0 && n_acc == n_sent) ? quiet_cyc + 1 : 0;
      if (n_acc == n_sent) begin
        v_n = 1'b0;
        if (stim_q.size() != 0) begin
          c = stim_q[0];
          case (c.kind)
            CMD_PIX: begin
              if ($urandom_range(99) >= idle_pct) begin
                void'(stim_q.pop_front());
                v_n = 1'b1;
                pix.pixel_x <= c.px;
                pix.pixel_y <= c.py;
                n_sent++;
              end
            end
            CMD_CFG: begin
              // block is idle once its last result has been taken
              if (quiet_cyc >= 4) begin
                void'(stim_q.pop_front());
                we_n = 1'b1;
                cfg_idx <= c.idx;
                cfg_data <= c.data;
                shadow_write(c.idx, c.data);
              end
            end
            CMD_DRAIN: if (basin_q.size() == 0) void'(stim_q.pop_front());
            CMD_PHASE: begin
              void'(stim_q.pop_front());
              idle_pct = c.idle_pct;
              stall_pct = c.stall_pct;
            end
            default: void'(stim_q.pop_front());
          endcase
        end else begin
          stim_done = 1'b1;
        end
      end
      pix.valid <= v_n;
      cfg_we <= we_n;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: rising edge. Predict on accept, compare on result.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    trace_res_t want;
    if (rst_ni) begin
      if (pix.valid && pix.ready) begin
        basin_q.push_back(trace_pixel(pix.pixel_x, pix.pixel_y));
        n_acc++;
      end
      if (res.valid && res.ready) begin
        n_res++;
        basin_hits[res.basin]++;
        if (basin_q.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("ERROR: result with nothing expected: basin %0d steps %0d",
                     res.basin, res.steps_taken);
        end else begin
          want = basin_q.pop_front();
          if (want.basin !== res.basin || want.steps !== res.steps_taken) begin
            n_err++;
            if (n_err <= 10)
              $display("ERROR: result %0d: expected basin %0d steps %0d, got basin %0d steps %0d",
                       n_res, want.basin, want.steps, res.basin, res.steps_taken);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int ax, ay;
    int lim_hi;
    pix.valid = 1'b0;
    pix.pixel_x = '0;
    pix.pixel_y = '0;
    res.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    stim_done = 1'b0;
    for (int i = 0; i < NumRegs; i++) regs_m[i] = '0;
    regs_m[RegA0X] = 20'd171418; regs_m[RegA0Y] = 20'd353894;
    regs_m[RegA1X] = 20'd447898; regs_m[RegA1Y] = 20'd442368;
    regs_m[RegA2X] = 20'd232243; regs_m[RegA2Y] = 20'd638976;
    regs_m[RegCap] = 20'd30;     regs_m[RegLim] = 20'd200;

    // Directed: reset setup, near each attractor (early capture) and one far pixel
    add_pix(670, 1382);
    add_pix(1750, 1728);
    add_pix(907, 2496);
    add_pix(2000, 100);
    // short limit for the pixel extremes, all of them off-image except the origin and (2159, 3839)
    add_cfg(RegLim, 5);
    add_pix(0, 0);
    add_pix(4095, 4095);
    add_pix(0, 4095);
    add_pix(4095, 0);
    add_pix(2159, 3839);
    add_pix(2160, 3840);
    // zero iteration limit: background with no steps
    add_cfg(RegLim, 0);
    add_pix(670, 1382);
    add_pix(4095, 4095);
    // zero capture distance with the particle sitting on an attractor: zero pull
    add_cfg(RegA0X, 100 << 8);
    add_cfg(RegA0Y, 100 << 8);
    add_cfg(RegCap, 0);
    add_cfg(RegLim, 3);
    add_pix(100, 100);
    // attractor coordinates at the extremes, maximum capture distance
    add_cfg(RegA1X, 0);
    add_cfg(RegA1Y, 20'hFFFFF);
    add_cfg(RegA2X, 20'hFFFFF);
    add_cfg(RegA2Y, 0);
    add_cfg(RegCap, 4095);
    add_pix(1000, 1000);
    add_cfg(RegCap, 20'hFF000);   // masks to zero
    add_pix(0, 4095);
    // one full-length trace at the largest limit, nothing can capture
    add_cfg(RegLim, 1023);
    add_pix(1234, 2345);

    // Random: four idling phases, setups changed every so often
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: add_phase(0, 0);
        1: add_phase(62, 0);
        2: add_phase(0, 62);
        default: add_phase(36, 36);
      endcase
      for (int blk = 0; blk < 5; blk++) begin
        lim_hi = ($urandom_range(4) == 0) ? 40 : 8;
        add_rand_cfg(lim_hi);
        for (int n = 0; n < 15; n++) begin
          if (n == 7 && blk == 2) add_drain();  // sender holds off until drained
          if ($urandom_range(1)) begin
            add_pix($urandom_range(4095), $urandom_range(4095));
          end else begin
            // start on the image so the whole-pixel evaluation dominates
            ax = $urandom_range(2159);
            ay = $urandom_range(3839);
            add_pix(ax, ay);
          end
        end
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (stim_done && n_acc == n_sent && basin_q.size() == 0);
    repeat (300) @(posedge clk_i);
    n_err += basin_q.size();
    $display("Traced %0d pixels, %0d results; basins 0/1/2/background: %0d/%0d/%0d/%0d",
             n_acc, n_res, basin_hits[0], basin_hits[1], basin_hits[2], basin_hits[3]);
    $display("Setups: reset, directed edge cases and 20 random, under four idling mixes.");
    if (n_err == 0) begin
      $display("** gravity_basin_pixel_tracer: PASSED **");
    end else begin
      $display("%0d mismatches", n_err);
      $display("** gravity_basin_pixel_tracer: FAILED **");
    end
    $finish;
  end

  // Run guard: many times the slowest expected run
  initial begin
    #1000ms;
    $display("Timeout: %0d sent, %0d accepted, %0d results", n_sent, n_acc, n_res);
    $display("** gravity_basin_pixel_tracer: FAILED **");
    $finish;
  end

endmodule
